>>> design/pbce_pkg.sv
// Shared types, constants and arithmetic helpers of the Bezier curve evaluator.
// No dependencies; every other design file imports this package.
package pbce_pkg;

    localparam int MAX_KNOTS   = 16;
    localparam int KNOT_AW     = $clog2(MAX_KNOTS);
    localparam int CNT_W       = 5;
    localparam int T_W         = 17;
    localparam int FRAC_W      = 16;
    localparam int FT_W        = T_W + CNT_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int DIF_W       = 33;
    localparam int M_W         = 34;
    localparam int Q_W         = 33;
    localparam int ACC_W       = 40;
    localparam int PRD_W       = ACC_W + T_W + 1;
    localparam int AXIS_STAGES = 11;

    localparam logic [T_W-1:0]   T_ONE     = T_W'(1 << FRAC_W);
    localparam logic [PRD_W-1:0] HALF_LSB  = PRD_W'(1 << (FRAC_W - 1));
    localparam int               DIV3_HI   = ((1 << 17) - 2) / 3;
    localparam int               DIV3_RCP  = ((1 << 21) + 1) / 3;
    localparam int               DIV3_SH   = 21;

    localparam logic [2:0] ACT_EVAL = 3'd0;
    localparam logic [2:0] ACT_POS  = 3'd1;
    localparam logic [2:0] ACT_OUT  = 3'd2;
    localparam logic [2:0] ACT_IN   = 3'd3;
    localparam logic [2:0] ACT_MODE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LOOP = CFG_IDX_W'(1);

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [PRD_W-1:0] prod_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         knot_index;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic               auto_flag;
        logic [16:0]        param_t;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
        logic [3:0]         segment;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        logic               we_pos;
        logic               we_oh;
        logic               we_ih;
        logic               we_mode;
        logic [KNOT_AW-1:0] idx;
        vec_t               vec;
        logic               flag;
    } wr_t;

    typedef struct packed {
        logic [KNOT_AW-1:0] pa;
        logic [KNOT_AW-1:0] a;
        logic [KNOT_AW-1:0] b;
        logic [KNOT_AW-1:0] qb;
    } raddr_t;

    typedef struct packed {
        vec_t pos_pa;
        vec_t pos_a;
        vec_t pos_b;
        vec_t pos_qb;
        vec_t oh_a;
        vec_t ih_b;
        logic auto_a;
        logic auto_b;
    } rdata_t;

    typedef struct packed {
        logic           cap_a;
        logic           cap_b;
        logic           auto_a;
        logic           auto_b;
        logic           deg;
        logic           one;
        logic [T_W-1:0] u;
    } ax_ctl_t;

    function automatic logic [M_W-1:0] hnd_mag(input logic signed [DIF_W-1:0] d,
                                               input logic cap);
        logic [M_W-1:0] a;
        a = d[DIF_W-1] ? M_W'(-d) : M_W'(d);
        return cap ? a + M_W'(1) : (a + M_W'(3)) >> 1;
    endfunction

    function automatic logic [Q_W-1:0] div3(input logic [M_W-1:0] m);
        logic [16:0]    hi;
        logic [16:0]    lo;
        logic [18:0]    v;
        logic [Q_W-1:0] qh;
        logic [38:0]    pv;
        hi = m[M_W-1:17];
        lo = m[16:0];
        qh = Q_W'(hi) * Q_W'(DIV3_HI);
        v  = {1'b0, hi, 1'b0} + 19'(lo);
        pv = 39'(v) * 39'(DIV3_RCP);
        return qh + Q_W'(pv[38:DIV3_SH]);
    endfunction

    function automatic acc_t rnd_q16(input prod_t p);
        logic [PRD_W-1:0] mag;
        logic [PRD_W-1:0] r;
        acc_t             rr;
        mag = p[PRD_W-1] ? PRD_W'(-p) : PRD_W'(p);
        r   = (mag + HALF_LSB) >> FRAC_W;
        rr  = acc_t'(r[ACC_W-1:0]);
        return p[PRD_W-1] ? -rr : rr;
    endfunction

    function automatic logic signed [31:0] sat32(input acc_t x);
        logic signed [31:0] r;
        if (x > acc_t'(32'sh7fffffff))
        begin
            r = 32'sh7fffffff;
        end
        else if (x < acc_t'(32'sh80000000))
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/pbce_knot_table.sv
// Knot table: duplicated position memories, handle memories and auto-mode bits.
// Depends on pbce_pkg; all reads are registered and advance with the pipeline enable.
module pbce_knot_table import pbce_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  wr_t    wr,
    input  raddr_t raddr,
    output rdata_t rdata
);

    vec_t                 pos0_mem [MAX_KNOTS];
    vec_t                 pos1_mem [MAX_KNOTS];
    vec_t                 oh_mem   [MAX_KNOTS];
    vec_t                 ih_mem   [MAX_KNOTS];
    logic [MAX_KNOTS-1:0] mode_reg;
    rdata_t               rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '1;
        end
        else if (wr.we_mode)
        begin
            mode_reg[wr.idx] <= wr.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr.we_pos)
            begin
                pos0_mem[wr.idx] <= wr.vec;
                pos1_mem[wr.idx] <= wr.vec;
            end
            if (wr.we_oh)
            begin
                oh_mem[wr.idx] <= wr.vec;
            end
            if (wr.we_ih)
            begin
                ih_mem[wr.idx] <= wr.vec;
            end
            rdata_reg.pos_pa <= pos0_mem[raddr.pa];
            rdata_reg.pos_a  <= pos0_mem[raddr.a];
            rdata_reg.pos_b  <= pos1_mem[raddr.b];
            rdata_reg.pos_qb <= pos1_mem[raddr.qb];
            rdata_reg.oh_a   <= oh_mem[raddr.a];
            rdata_reg.ih_b   <= ih_mem[raddr.b];
            rdata_reg.auto_a <= mode_reg[raddr.a];
            rdata_reg.auto_b <= mode_reg[raddr.b];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pbce_axis_pipe.sv
// One coordinate of the evaluator: handles, control points, Horner position and slope.
// Depends on pbce_pkg; eleven register stages that advance with the pipeline enable.
module pbce_axis_pipe import pbce_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  ax_ctl_t            ctl,
    input  logic signed [31:0] pos_pa,
    input  logic signed [31:0] pos_a,
    input  logic signed [31:0] pos_b,
    input  logic signed [31:0] pos_qb,
    input  logic signed [31:0] oh,
    input  logic signed [31:0] ih,
    output logic signed [31:0] pos,
    output logic signed [31:0] tan
);

    ax_ctl_t            ctl_line_reg [AXIS_STAGES-1];
    logic signed [31:0] p0_line_reg  [AXIS_STAGES-1];

    logic [M_W-1:0]     a1_ma_reg, a1_mb_reg, a1_ma_next, a1_mb_next;
    logic               a1_sa_reg, a1_sb_reg;
    logic signed [31:0] a1_p3_reg, a1_oh_reg, a1_ih_reg;
    logic signed [DIF_W-1:0] d_a, d_b;
    acc_t               a2_h1_reg, a2_h2_reg, a2_h1_next, a2_h2_next;
    logic signed [31:0] a2_p3_reg;
    acc_t               a3_p1_reg, a3_p2_reg, a3_h1_reg, a3_p1_next, a3_p2_next;
    logic signed [31:0] a3_p3_reg;
    acc_t               a4_e_reg, a4_f_reg, a4_g_reg, a4_c1_reg;
    acc_t               a4_e_next, a4_f_next, a4_g_next, a4_c1_next;
    acc_t               a5_c1_reg, a5_c2_reg, a5_c3_reg, a5_d2_reg, a5_d3_reg;
    acc_t               a5_c2_next, a5_c3_next, a5_d2_next, a5_d3_next;
    prod_t              a6_mp_reg, a6_md_reg, a6_mp_next, a6_md_next;
    acc_t               a6_c1_reg, a6_c2_reg, a6_d2_reg;
    acc_t               a7_ap_reg, a7_ad_reg, a7_c1_reg, a7_ap_next, a7_ad_next;
    prod_t              a8_mp_reg, a8_md_reg, a8_mp_next, a8_md_next;
    acc_t               a8_c1_reg;
    acc_t               a9_ap_reg, a9_ap_next;
    logic signed [31:0] a9_tan_reg, a9_tan_next;
    prod_t              a10_mp_reg, a10_mp_next;
    logic signed [31:0] a10_tan_reg;
    logic signed [31:0] pos_reg, tan_reg, pos_next, tan_next;
    logic [Q_W-1:0]     qa, qb;
    prod_t              u6, u8, u10;

    always_comb
    begin
        d_a = DIF_W'(pos_b) - (ctl.cap_a ? DIF_W'(pos_a) : DIF_W'(pos_pa));
        d_b = (ctl.cap_b ? DIF_W'(pos_b) : DIF_W'(pos_qb)) - DIF_W'(pos_a);
        a1_ma_next = hnd_mag(d_a, ctl.cap_a);
        a1_mb_next = hnd_mag(d_b, ctl.cap_b);

        qa = div3(a1_ma_reg);
        qb = div3(a1_mb_reg);
        a2_h1_next = ctl_line_reg[0].auto_a ? (a1_sa_reg ? -acc_t'(qa) : acc_t'(qa))
                                            : acc_t'(a1_oh_reg);
        a2_h2_next = ctl_line_reg[0].auto_b ? (a1_sb_reg ? acc_t'(qb) : -acc_t'(qb))
                                            : acc_t'(a1_ih_reg);

        a3_p1_next = acc_t'(p0_line_reg[1]) + a2_h1_reg;
        a3_p2_next = acc_t'(a2_p3_reg) + a2_h2_reg;

        a4_e_next  = a3_p1_reg - a3_p2_reg;
        a4_f_next  = acc_t'(a3_p3_reg) - acc_t'(p0_line_reg[2]);
        a4_g_next  = acc_t'(p0_line_reg[2]) - (a3_p1_reg <<< 1) + a3_p2_reg;
        a4_c1_next = a3_h1_reg + (a3_h1_reg <<< 1);

        a5_c2_next = a4_g_reg + (a4_g_reg <<< 1);
        a5_c3_next = a4_f_reg + a4_e_reg + (a4_e_reg <<< 1);
        a5_d2_next = (a4_g_reg <<< 1) + (a4_g_reg <<< 2);
        a5_d3_next = a4_f_reg + (a4_f_reg <<< 1) + a4_e_reg + (a4_e_reg <<< 3);

        u6 = prod_t'($signed({1'b0, ctl_line_reg[4].u}));
        a6_mp_next = prod_t'(a5_c3_reg) * u6;
        a6_md_next = prod_t'(a5_d3_reg) * u6;

        a7_ap_next = rnd_q16(a6_mp_reg) + a6_c2_reg;
        a7_ad_next = rnd_q16(a6_md_reg) + a6_d2_reg;

        u8 = prod_t'($signed({1'b0, ctl_line_reg[6].u}));
        a8_mp_next = prod_t'(a7_ap_reg) * u8;
        a8_md_next = prod_t'(a7_ad_reg) * u8;

        a9_ap_next  = rnd_q16(a8_mp_reg) + a8_c1_reg;
        a9_tan_next = sat32(rnd_q16(a8_md_reg) + a8_c1_reg);

        u10 = prod_t'($signed({1'b0, ctl_line_reg[8].u}));
        a10_mp_next = prod_t'(a9_ap_reg) * u10;

        if (ctl_line_reg[9].deg)
        begin
            pos_next = ctl_line_reg[9].one ? p0_line_reg[9] : 32'sd0;
            tan_next = 32'sd0;
        end
        else
        begin
            pos_next = sat32(rnd_q16(a10_mp_reg) + acc_t'(p0_line_reg[9]));
            tan_next = a10_tan_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_line_reg[0] <= ctl;
            p0_line_reg[0]  <= pos_a;
            for (int k = 1; k < AXIS_STAGES - 1; k++)
            begin
                ctl_line_reg[k] <= ctl_line_reg[k-1];
                p0_line_reg[k]  <= p0_line_reg[k-1];
            end
            a1_ma_reg   <= a1_ma_next;
            a1_mb_reg   <= a1_mb_next;
            a1_sa_reg   <= d_a[DIF_W-1];
            a1_sb_reg   <= d_b[DIF_W-1];
            a1_p3_reg   <= pos_b;
            a1_oh_reg   <= oh;
            a1_ih_reg   <= ih;
            a2_h1_reg   <= a2_h1_next;
            a2_h2_reg   <= a2_h2_next;
            a2_p3_reg   <= a1_p3_reg;
            a3_p1_reg   <= a3_p1_next;
            a3_p2_reg   <= a3_p2_next;
            a3_h1_reg   <= a2_h1_reg;
            a3_p3_reg   <= a2_p3_reg;
            a4_e_reg    <= a4_e_next;
            a4_f_reg    <= a4_f_next;
            a4_g_reg    <= a4_g_next;
            a4_c1_reg   <= a4_c1_next;
            a5_c1_reg   <= a4_c1_reg;
            a5_c2_reg   <= a5_c2_next;
            a5_c3_reg   <= a5_c3_next;
            a5_d2_reg   <= a5_d2_next;
            a5_d3_reg   <= a5_d3_next;
            a6_mp_reg   <= a6_mp_next;
            a6_md_reg   <= a6_md_next;
            a6_c1_reg   <= a5_c1_reg;
            a6_c2_reg   <= a5_c2_reg;
            a6_d2_reg   <= a5_d2_reg;
            a7_ap_reg   <= a7_ap_next;
            a7_ad_reg   <= a7_ad_next;
            a7_c1_reg   <= a6_c1_reg;
            a8_mp_reg   <= a8_mp_next;
            a8_md_reg   <= a8_md_next;
            a8_c1_reg   <= a7_c1_reg;
            a9_ap_reg   <= a9_ap_next;
            a9_tan_reg  <= a9_tan_next;
            a10_mp_reg  <= a10_mp_next;
            a10_tan_reg <= a9_tan_reg;
            pos_reg     <= pos_next;
            tan_reg     <= tan_next;
        end
    end

    assign pos = pos_reg;
    assign tan = tan_reg;

endmodule

>>> design/piecewise_bezier_curve_evaluator.sv
// Top level of the piecewise cubic Bezier curve evaluator with auto tangents.
// Depends on pbce_pkg, pbce_knot_table and pbce_axis_pipe.
//
//   channel | signals                               | moves
//   --------+---------------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data           | write or evaluate transaction
//   out     | out_valid, out_ready, out_data        | position, tangent, segment
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | knot_count, closed_loop write
//
// One transaction enters per cycle unless the output stalls; an evaluate result passes through
// the input register, address stage, table read and 11 arithmetic stages before it is presented.
// Writes land in the table from the input register and give no result.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits and config and sets every knot to auto mode.
module piecewise_bezier_curve_evaluator import pbce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0]   knot_count_reg;
    logic               closed_loop_reg;
    logic               en;

    logic               s0_valid_reg;
    in_t                s0_data_reg;
    wr_t                wr;

    logic [CNT_W-1:0]   n, nseg, seg, b5, pa5, qb5;
    logic               deg, one;
    logic [T_W-1:0]     t, u;
    logic [FT_W-1:0]    ft;
    logic [FT_W-FRAC_W-1:0] seg_raw;

    logic               s1_valid_reg;
    raddr_t             s1_addr_reg, s1_addr_next;
    ax_ctl_t            s1_ctl_reg, s1_ctl_next;
    logic [3:0]         s1_seg_reg;

    logic               s2_valid_reg;
    ax_ctl_t            s2_ctl_reg;
    logic [3:0]         s2_seg_reg;
    rdata_t             rdata;
    ax_ctl_t            ax_ctl;

    logic               vld_line_reg [AXIS_STAGES];
    logic [3:0]         seg_line_reg [AXIS_STAGES];

    assign cfg_ready = 1'b1;
    assign out_valid = vld_line_reg[AXIS_STAGES-1];
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg  <= '0;
            closed_loop_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_KNOT_COUNT)
            begin
                knot_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_CLOSED_LOOP)
            begin
                closed_loop_reg <= cfg_data[0];
            end
        end
    end

    always_comb
    begin
        wr.idx     = s0_data_reg.knot_index;
        wr.vec     = '{s0_data_reg.vec_x, s0_data_reg.vec_y, s0_data_reg.vec_z};
        wr.flag    = s0_data_reg.auto_flag;
        wr.we_pos  = en && s0_valid_reg && s0_data_reg.action == ACT_POS;
        wr.we_oh   = en && s0_valid_reg && s0_data_reg.action == ACT_OUT;
        wr.we_ih   = en && s0_valid_reg && s0_data_reg.action == ACT_IN;
        wr.we_mode = en && s0_valid_reg && s0_data_reg.action == ACT_MODE;
    end

    always_comb
    begin
        n    = knot_count_reg > CNT_W'(MAX_KNOTS) ? CNT_W'(MAX_KNOTS) : knot_count_reg;
        deg  = n < CNT_W'(2);
        one  = n == CNT_W'(1);
        nseg = deg ? '0 : (closed_loop_reg ? n : n - CNT_W'(1));
        t    = s0_data_reg.param_t > T_ONE ? T_ONE : s0_data_reg.param_t;
        ft   = FT_W'(t) * FT_W'(nseg);
        seg_raw = ft[FT_W-1:FRAC_W];
        if (deg)
        begin
            seg = '0;
        end
        else if (seg_raw > (FT_W-FRAC_W)'(nseg - CNT_W'(1)))
        begin
            seg = nseg - CNT_W'(1);
        end
        else
        begin
            seg = CNT_W'(seg_raw);
        end
        u   = T_W'(ft - (FT_W'(seg) << FRAC_W));
        b5  = (closed_loop_reg && seg + CNT_W'(1) == n) ? '0 : seg + CNT_W'(1);
        pa5 = (seg == '0) ? (closed_loop_reg ? n - CNT_W'(1) : '0) : seg - CNT_W'(1);
        if (b5 + CNT_W'(1) == n)
        begin
            qb5 = closed_loop_reg ? '0 : b5;
        end
        else
        begin
            qb5 = b5 + CNT_W'(1);
        end

        s1_addr_next.pa  = pa5[KNOT_AW-1:0];
        s1_addr_next.a   = seg[KNOT_AW-1:0];
        s1_addr_next.b   = b5[KNOT_AW-1:0];
        s1_addr_next.qb  = qb5[KNOT_AW-1:0];
        s1_ctl_next.cap_a  = !closed_loop_reg && seg == '0;
        s1_ctl_next.cap_b  = !closed_loop_reg && b5 == n - CNT_W'(1);
        s1_ctl_next.auto_a = 1'b0;
        s1_ctl_next.auto_b = 1'b0;
        s1_ctl_next.deg    = deg;
        s1_ctl_next.one    = one;
        s1_ctl_next.u      = u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < AXIS_STAGES; k++)
            begin
                vld_line_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            s1_valid_reg    <= s0_valid_reg && s0_data_reg.action == ACT_EVAL;
            s2_valid_reg    <= s1_valid_reg;
            vld_line_reg[0] <= s2_valid_reg;
            for (int k = 1; k < AXIS_STAGES; k++)
            begin
                vld_line_reg[k] <= vld_line_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid)
            begin
                s0_data_reg <= in_data;
            end
            s1_addr_reg     <= s1_addr_next;
            s1_ctl_reg      <= s1_ctl_next;
            s1_seg_reg      <= seg[3:0];
            s2_ctl_reg      <= s1_ctl_reg;
            s2_seg_reg      <= s1_seg_reg;
            seg_line_reg[0] <= s2_seg_reg;
            for (int k = 1; k < AXIS_STAGES; k++)
            begin
                seg_line_reg[k] <= seg_line_reg[k-1];
            end
        end
    end

    pbce_knot_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .wr    (wr),
        .raddr (s1_addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        ax_ctl        = s2_ctl_reg;
        ax_ctl.auto_a = rdata.auto_a;
        ax_ctl.auto_b = rdata.auto_b;
    end

    pbce_axis_pipe u_axis_x
    (
        .clk    (clk),
        .en     (en),
        .ctl    (ax_ctl),
        .pos_pa (rdata.pos_pa.x),
        .pos_a  (rdata.pos_a.x),
        .pos_b  (rdata.pos_b.x),
        .pos_qb (rdata.pos_qb.x),
        .oh     (rdata.oh_a.x),
        .ih     (rdata.ih_b.x),
        .pos    (out_data.pos_x),
        .tan    (out_data.tan_x)
    );

    pbce_axis_pipe u_axis_y
    (
        .clk    (clk),
        .en     (en),
        .ctl    (ax_ctl),
        .pos_pa (rdata.pos_pa.y),
        .pos_a  (rdata.pos_a.y),
        .pos_b  (rdata.pos_b.y),
        .pos_qb (rdata.pos_qb.y),
        .oh     (rdata.oh_a.y),
        .ih     (rdata.ih_b.y),
        .pos    (out_data.pos_y),
        .tan    (out_data.tan_y)
    );

    pbce_axis_pipe u_axis_z
    (
        .clk    (clk),
        .en     (en),
        .ctl    (ax_ctl),
        .pos_pa (rdata.pos_pa.z),
        .pos_a  (rdata.pos_a.z),
        .pos_b  (rdata.pos_b.z),
        .pos_qb (rdata.pos_qb.z),
        .oh     (rdata.oh_a.z),
        .ih     (rdata.ih_b.z),
        .pos    (out_data.pos_z),
        .tan    (out_data.tan_z)
    );

    assign out_data.segment = seg_line_reg[AXIS_STAGES-1];

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        en && s0_valid_reg && s0_data_reg.action != ACT_EVAL |=> !s1_valid_reg)
        else $error("write transaction entered the evaluate pipeline");

    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_ctl_reg.u <= T_ONE)
        else $error("local parameter out of range");

    a_deg_seg: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_ctl_reg.deg |-> s2_seg_reg == 4'd0)
        else $error("degenerate curve with nonzero segment");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && s2_valid_reg |=> vld_line_reg[0])
        else $error("evaluate transaction dropped after table read");

endmodule

>>> test/testbench.sv
// Self-checking testbench of piecewise_bezier_curve_evaluator: a directed table, then
// random write/evaluate traffic over several knot_count/closed_loop settings.
// Depends on pbce_pkg and the design files; checks against a built-in curve predictor.
`timescale 1ns / 1ps

module testbench;
    import pbce_pkg::*;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_LITERAL} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        count;
        bit        loop;
        in_t       item;
        out_t      want;
    } plan_row_t;

    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_t                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    out_t      expected_samples[$];
    plan_row_t plan[$];
    int        failures = 0;
    bit        steady   = 0;
    bit        choke    = 0;

    longint    knot_pos[3][MAX_KNOTS];
    longint    knot_oh[3][MAX_KNOTS];
    longint    knot_ih[3][MAX_KNOTS];
    bit        knot_auto[MAX_KNOTS];
    int        model_count;
    bit        model_loop;

    piecewise_bezier_curve_evaluator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("piecewise_bezier_curve_evaluator verification failed");
        $finish;
    end

    function automatic longint round_div(longint x, longint d);
        if (x < 0)
        begin
            return -((-x + d / 2) / d);
        end
        return (x + d / 2) / d;
    endfunction

    function automatic logic [31:0] clip32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function automatic longint tangent_third(int ax, int n, int i);
        int p;
        int q;
        if (model_loop)
        begin
            p = (i + n - 1) % n;
            q = (i + 1) % n;
        end
        else
        begin
            p = (i > 0) ? i - 1 : i;
            q = (i + 1 < n) ? i + 1 : i;
        end
        if (p == i)
        begin
            return round_div(knot_pos[ax][q] - knot_pos[ax][i], 3);
        end
        if (q == i)
        begin
            return round_div(knot_pos[ax][i] - knot_pos[ax][p], 3);
        end
        return round_div(knot_pos[ax][q] - knot_pos[ax][p], 6);
    endfunction

    function automatic void bezier_axis(int ax, int n, int a, int b, longint u,
                                        output logic [31:0] pos, output logic [31:0] tng);
        longint p0;
        longint p1;
        longint p2;
        longint p3;
        longint c1;
        longint c2;
        longint c3;
        longint acc;
        p0 = knot_pos[ax][a];
        p3 = knot_pos[ax][b];
        p1 = p0 + (knot_auto[a] ? tangent_third(ax, n, a) : knot_oh[ax][a]);
        p2 = p3 + (knot_auto[b] ? -tangent_third(ax, n, b) : knot_ih[ax][b]);
        c1 = 3 * (p1 - p0);
        c2 = 3 * (p0 - 2 * p1 + p2);
        c3 = p3 - p0 + 3 * (p1 - p2);
        acc = round_div(c3 * u, 65536) + c2;
        acc = round_div(acc * u, 65536) + c1;
        acc = round_div(acc * u, 65536) + p0;
        pos = clip32(acc);
        acc = round_div(3 * c3 * u, 65536) + 2 * c2;
        acc = round_div(acc * u, 65536) + c1;
        tng = clip32(acc);
    endfunction

    // Update the knot table; return 1 with the curve sample for an evaluate.
    function automatic bit curve_step(in_t it, output out_t res);
        longint v[3];
        int     n;
        int     nseg;
        int     seg;
        int     b;
        longint t;
        longint ft;
        v[0] = longint'($signed(it.vec_x));
        v[1] = longint'($signed(it.vec_y));
        v[2] = longint'($signed(it.vec_z));
        res = '0;
        if (it.action != ACT_EVAL)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                case (it.action)
                    ACT_POS: knot_pos[ax][it.knot_index] = v[ax];
                    ACT_OUT: knot_oh[ax][it.knot_index] = v[ax];
                    ACT_IN:  knot_ih[ax][it.knot_index] = v[ax];
                    default: ;
                endcase
            end
            if (it.action == ACT_MODE)
            begin
                knot_auto[it.knot_index] = it.auto_flag;
            end
            return 0;
        end
        n = (model_count > MAX_KNOTS) ? MAX_KNOTS : model_count;
        nseg = (n < 2) ? 0 : (model_loop ? n : n - 1);
        if (nseg == 0)
        begin
            if (n == 1)
            begin
                res.pos_x = clip32(knot_pos[0][0]);
                res.pos_y = clip32(knot_pos[1][0]);
                res.pos_z = clip32(knot_pos[2][0]);
            end
            return 1;
        end
        t = it.param_t;
        if (t > 65536)
        begin
            t = 65536;
        end
        ft = t * nseg;
        seg = int'(ft >> 16);
        if (seg > nseg - 1)
        begin
            seg = nseg - 1;
        end
        b = model_loop ? (seg + 1) % n : seg + 1;
        bezier_axis(0, n, seg, b, ft - (longint'(seg) << 16), res.pos_x, res.tan_x);
        bezier_axis(1, n, seg, b, ft - (longint'(seg) << 16), res.pos_y, res.tan_y);
        bezier_axis(2, n, seg, b, ft - (longint'(seg) << 16), res.pos_z, res.tan_z);
        res.segment = seg[3:0];
        return 1;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
        endcase
    endfunction

    function automatic in_t make_item(logic [2:0] action, logic [3:0] k, logic [16:0] t);
        in_t it;
        it.action     = action;
        it.knot_index = k;
        it.vec_x      = pick_coord();
        it.vec_y      = pick_coord();
        it.vec_z      = pick_coord();
        it.auto_flag  = 1'($urandom_range(0, 1));
        it.param_t    = t;
        return it;
    endfunction

    function automatic void add_cfg(int count, bit loop);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.count = count;
        r.loop  = loop;
        r.item  = '0;
        r.want  = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_item(in_t it, row_kind_t kind = ROW_ITEM, out_t want = '0);
        plan_row_t r;
        r.kind  = kind;
        r.count = 0;
        r.loop  = 0;
        r.item  = it;
        r.want  = want;
        plan.insert(plan.size(), r);
    endfunction

    task automatic wait_idle();
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == CFG_KNOT_COUNT)
        begin
            model_count = val;
        end
        else
        begin
            model_loop = val[0];
        end
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic send_row(plan_row_t r);
        out_t res;
        if (r.kind == ROW_CFG)
        begin
            wait_idle();
            write_reg(CFG_KNOT_COUNT, CFG_DATA_W'(r.count));
            write_reg(CFG_CLOSED_LOOP, CFG_DATA_W'(r.loop));
            return;
        end
        if (!steady && $urandom_range(0, 7) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1;
        in_data  = r.item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (curve_step(r.item, res))
        begin
            expected_samples.insert(expected_samples.size(),
                                    r.kind == ROW_LITERAL ? r.want : res);
        end
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected sample expected none actual %h", $time, out_data);
            end
            else
            begin
                out_t w;
                w = expected_samples.pop_front();
                report("pos_x", w.pos_x, out_data.pos_x);
                report("pos_y", w.pos_y, out_data.pos_y);
                report("pos_z", w.pos_z, out_data.pos_z);
                report("tan_x", w.tan_x, out_data.tan_x);
                report("tan_y", w.tan_y, out_data.tan_y);
                report("tan_z", w.tan_z, out_data.tan_z);
                report("segment", 32'(w.segment), 32'(out_data.segment));
            end
        end
    end

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (choke)
            begin
                out_ready = 0;
                repeat (400) @(negedge clk);
                choke = 0;
                out_ready = 1;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ready = 1;
            end
            else
            begin
                out_ready = 1;
            end
        end
    end

    initial
    begin
        in_t  it;
        out_t want;
        int   counts[10] = '{2, 16, 0, 1, 31, 3, 5, 16, 2, 10};
        bit   loops[10]  = '{0, 1, 0, 1, 1, 1, 0, 0, 1, 1};
        int   roll;

        rst_n     = 0;
        in_valid  = 0;
        in_data   = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            for (int k = 0; k < MAX_KNOTS; k++)
            begin
                knot_pos[ax][k] = 0;
                knot_oh[ax][k]  = 0;
                knot_ih[ax][k]  = 0;
            end
        end
        for (int k = 0; k < MAX_KNOTS; k++)
        begin
            knot_auto[k] = 1;
        end
        model_count = 0;
        model_loop  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: empty curve, single knot at extremes, ignored actions.
        want = '0;
        add_item(make_item(ACT_EVAL, 4'd0, 17'd0), ROW_LITERAL, want);
        add_item(make_item(ACT_EVAL, 4'd0, 17'h1ffff), ROW_LITERAL, want);
        it = make_item(ACT_POS, 4'd0, 17'd0);
        it.vec_x = 32'h7fffffff;
        it.vec_y = 32'h80000000;
        it.vec_z = 32'h0;
        add_item(it);
        add_cfg(1, 0);
        want.pos_x = 32'h7fffffff;
        want.pos_y = 32'h80000000;
        add_item(make_item(ACT_EVAL, 4'd0, 17'd40000), ROW_LITERAL, want);
        add_item(make_item(ACT_SPARE_A, 4'd0, 17'd0));
        add_item(make_item(ACT_SPARE_B, 4'd1, 17'd0));
        add_item(make_item(ACT_SPARE_C, 4'd15, 17'd0));
        add_item(make_item(ACT_EVAL, 4'd0, 17'd0), ROW_LITERAL, want);
        foreach (plan[i])
        begin
            send_row(plan[i]);
        end
        plan.delete();

        // Load every knot so no evaluate reads an unwritten entry.
        for (int k = 0; k < MAX_KNOTS; k++)
        begin
            add_item(make_item(ACT_POS, 4'(k), 17'd0));
            add_item(make_item(ACT_OUT, 4'(k), 17'd0));
            add_item(make_item(ACT_IN, 4'(k), 17'd0));
        end
        add_cfg(2, 0);
        add_item(make_item(ACT_EVAL, 4'd0, 17'd0));
        add_item(make_item(ACT_EVAL, 4'd0, 17'd65536));
        add_item(make_item(ACT_EVAL, 4'd0, 17'h1ffff));
        add_item(make_item(ACT_MODE, 4'd0, 17'd0));
        add_item(make_item(ACT_EVAL, 4'd0, 17'd32768));
        add_cfg(16, 1);
        add_item(make_item(ACT_EVAL, 4'd0, 17'd65535));
        add_item(make_item(ACT_EVAL, 4'd0, 17'd0));
        add_cfg(31, 0);
        add_item(make_item(ACT_EVAL, 4'd0, 17'd65536));
        add_item(make_item(ACT_EVAL, 4'd0, 17'd30000));
        foreach (plan[i])
        begin
            send_row(plan[i]);
        end
        plan.delete();

        // Random phases over a range of curve settings.
        for (int ph = 0; ph < 10; ph++)
        begin
            add_cfg(counts[ph], loops[ph]);
            send_row(plan.pop_front());
            if (ph == 1)
            begin
                choke = 1;
            end
            if (ph == 9)
            begin
                steady = 1;
            end
            for (int i = 0; i < 110; i++)
            begin
                roll = $urandom_range(0, 19);
                if (roll < 10)
                begin
                    it = make_item(ACT_EVAL, 4'($urandom),
                                   ($urandom_range(0, 7) == 0) ? 17'($urandom)
                                                               : 17'($urandom_range(0, 65536)));
                end
                else if (roll < 18)
                begin
                    it = make_item(3'($urandom_range(ACT_POS, ACT_MODE)), 4'($urandom),
                                   17'($urandom));
                end
                else
                begin
                    it = make_item(3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C)), 4'($urandom),
                                   17'($urandom));
                end
                add_item(it);
                send_row(plan.pop_front());
            end
        end

        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("piecewise_bezier_curve_evaluator verification clean");
        end
        else
        begin
            $display("piecewise_bezier_curve_evaluator verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/pbce_pkg.sv
design/pbce_knot_table.sv
design/pbce_axis_pipe.sv
design/piecewise_bezier_curve_evaluator.sv
test/testbench.sv
